/* hdl/plsa_pkg.sv */
`default_nettype none
package plsa_pkg;

    localparam int SCENE_ID_BITS_DEF = 4;

    localparam int CFG_DATA_BITS = 31;
    localparam int CFG_IDX_BITS  = 3;

    localparam int MS_PER_S  = 1000;
    localparam int SOFT_BITS = 26;

    localparam logic [2:0]  MAX_PRIORITY_RST     = 3'd5;
    localparam logic [15:0] DEFAULT_DURATION_RST = 16'd30;
    localparam logic [15:0] MAX_DURATION_RST     = 16'd3600;
    localparam logic [30:0] HARD_TTL_RST         = 31'(60 * 60 * MS_PER_S);
    localparam int          DEFAULT_SCENE_RST    = 1;
    localparam logic [31:0] SEQ_RST              = 32'd1;

    typedef enum logic [1:0] {
        OP_REQUEST   = 2'd0,
        OP_TICK      = 2'd1,
        OP_OVERRIDE  = 2'd2,
        OP_CLR_STICK = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAX_PRIORITY     = 3'd0,
        CFG_DEFAULT_DURATION = 3'd1,
        CFG_MAX_DURATION     = 3'd2,
        CFG_HARD_TTL         = 3'd3,
        CFG_DEFAULT_SCENE    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]  max_priority;
        logic [15:0] dflt_lease_secs;
        logic [15:0] max_lease_secs;
        logic [30:0] hard_ttl_ms;
    } cfg_t;

    typedef struct packed {
        op_t         opcode;
        logic [7:0]  req_priority;
        logic [15:0] lease_secs;
        logic        req_sticky;
        logic        from_user;
        logic [1:0]  override_sel;
        logic        override_on;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic        published;
        logic [2:0]  held_priority;
        logic        held_sticky;
        logic [31:0] change_count;
        logic [3:0]  flags;
    } res_t;

endpackage
`default_nettype wire

/* hdl/plsa_cfg.sv */
`default_nettype none
module plsa_cfg
    import plsa_pkg::*;
#(
    parameter int SCENE_ID_BITS = SCENE_ID_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                          cfg,
    output logic [SCENE_ID_BITS-1:0]      default_scene
);

    cfg_t                     cfg_reg;
    logic [SCENE_ID_BITS-1:0] dscene_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_priority    <= MAX_PRIORITY_RST;
            cfg_reg.dflt_lease_secs <= DEFAULT_DURATION_RST;
            cfg_reg.max_lease_secs  <= MAX_DURATION_RST;
            cfg_reg.hard_ttl_ms     <= HARD_TTL_RST;
            dscene_reg              <= SCENE_ID_BITS'(DEFAULT_SCENE_RST);
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_PRIORITY:     cfg_reg.max_priority <= cfg_wdata[2:0];
                CFG_DEFAULT_DURATION: cfg_reg.dflt_lease_secs <= cfg_wdata[15:0];
                CFG_MAX_DURATION:     cfg_reg.max_lease_secs <= cfg_wdata[15:0];
                CFG_HARD_TTL:         cfg_reg.hard_ttl_ms <= cfg_wdata[30:0];
                CFG_DEFAULT_SCENE:    dscene_reg <= cfg_wdata[SCENE_ID_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg           = cfg_reg;
    assign default_scene = dscene_reg;

endmodule
`default_nettype wire

/* hdl/plsa_core.sv */
`default_nettype none
module plsa_core
    import plsa_pkg::*;
#(
    parameter int SCENE_ID_BITS = SCENE_ID_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     fire,
    input  wire item_t                    item,
    input  wire logic [SCENE_ID_BITS-1:0] scene_id,
    input  wire cfg_t                     cfg,
    input  wire logic [SCENE_ID_BITS-1:0] default_scene,
    output res_t                          res,
    output logic [SCENE_ID_BITS-1:0]      res_scene
);

    logic [SCENE_ID_BITS-1:0] held_scene_reg, held_scene_next;
    logic [2:0]               held_prio_reg, held_prio_next;
    logic                     held_sticky_reg, held_sticky_next;
    logic [31:0]              soft_dl_reg, soft_dl_next;
    logic                     soft_valid_reg, soft_valid_next;
    logic [31:0]              hard_dl_reg, hard_dl_next;
    logic [3:0]               flags_reg, flags_next;
    logic [31:0]              seq_reg, seq_next;
    logic [SCENE_ID_BITS-1:0] last_pub_reg, last_pub_next;

    logic [2:0]           prio_clamped;
    logic [15:0]          dur_pick;
    logic [15:0]          dur_capped;
    logic [SOFT_BITS-1:0] soft_ms;
    logic [31:0]          soft_sum;
    logic [31:0]          hard_sum;
    logic [31:0]          soft_diff;
    logic [31:0]          hard_diff;
    logic                 soft_expired;
    logic                 hard_expired;
    logic                 at_default;
    logic                 accepted;
    logic                 published;

    // Request and deadline arithmetic: clamps, a constant multiply, adds and wrapped differences.
    always_comb begin
        prio_clamped = (item.req_priority > {5'd0, cfg.max_priority}) ?
                       cfg.max_priority : item.req_priority[2:0];
        dur_pick     = (item.lease_secs == 16'd0) ? cfg.dflt_lease_secs : item.lease_secs;
        dur_capped   = (dur_pick > cfg.max_lease_secs) ? cfg.max_lease_secs : dur_pick;
        soft_ms      = SOFT_BITS'(dur_capped) * SOFT_BITS'(MS_PER_S);
        soft_sum     = item.now_ms + 32'(soft_ms);
        hard_sum     = item.now_ms + {1'b0, cfg.hard_ttl_ms};
        // Deadlines are due once the wrapped difference is non-negative.
        soft_diff    = item.now_ms - soft_dl_reg;
        hard_diff    = item.now_ms - hard_dl_reg;
        soft_expired = soft_valid_reg && !soft_diff[31];
        hard_expired = !hard_diff[31];
        at_default   = (held_scene_reg == default_scene) && (held_prio_reg == 3'd0) &&
                       !held_sticky_reg;
    end

    always_comb begin
        held_scene_next  = held_scene_reg;
        held_prio_next   = held_prio_reg;
        held_sticky_next = held_sticky_reg;
        soft_dl_next     = soft_dl_reg;
        soft_valid_next  = soft_valid_reg;
        hard_dl_next     = hard_dl_reg;
        flags_next       = flags_reg;
        seq_next         = seq_reg;
        last_pub_next    = last_pub_reg;
        accepted         = 1'b0;
        published        = 1'b0;

        unique case (item.opcode)
            OP_REQUEST: begin
                if (item.from_user || (prio_clamped >= held_prio_reg)) begin
                    held_scene_next  = scene_id;
                    held_prio_next   = prio_clamped;
                    held_sticky_next = item.req_sticky;
                    soft_valid_next  = !item.req_sticky;
                    soft_dl_next     = item.req_sticky ? 32'd0 : soft_sum;
                    hard_dl_next     = hard_sum;
                    accepted         = 1'b1;
                    published        = 1'b1;
                end
            end
            OP_TICK: begin
                if ((soft_expired || hard_expired) && !at_default) begin
                    held_scene_next  = default_scene;
                    held_prio_next   = 3'd0;
                    held_sticky_next = 1'b0;
                    soft_valid_next  = 1'b0;
                    soft_dl_next     = 32'd0;
                    hard_dl_next     = hard_sum;
                    published        = 1'b1;
                end
            end
            OP_OVERRIDE: begin
                if (flags_reg[item.override_sel] != item.override_on) begin
                    flags_next[item.override_sel] = item.override_on;
                    published = 1'b1;
                end
            end
            OP_CLR_STICK: begin
                if (held_sticky_reg) begin
                    held_scene_next  = default_scene;
                    held_prio_next   = 3'd0;
                    held_sticky_next = 1'b0;
                    soft_valid_next  = 1'b0;
                    soft_dl_next     = 32'd0;
                    hard_dl_next     = hard_sum;
                    published        = 1'b1;
                end
            end
            default: ;
        endcase

        if (published && (held_scene_next != last_pub_reg)) begin
            seq_next      = seq_reg + 32'd1;
            last_pub_next = held_scene_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_scene_reg  <= SCENE_ID_BITS'(DEFAULT_SCENE_RST);
            held_prio_reg   <= 3'd0;
            held_sticky_reg <= 1'b0;
            soft_dl_reg     <= 32'd0;
            soft_valid_reg  <= 1'b0;
            hard_dl_reg     <= 32'd0;
            flags_reg       <= 4'd0;
            seq_reg         <= SEQ_RST;
            last_pub_reg    <= SCENE_ID_BITS'(DEFAULT_SCENE_RST);
        end else if (fire) begin
            held_scene_reg  <= held_scene_next;
            held_prio_reg   <= held_prio_next;
            held_sticky_reg <= held_sticky_next;
            soft_dl_reg     <= soft_dl_next;
            soft_valid_reg  <= soft_valid_next;
            hard_dl_reg     <= hard_dl_next;
            flags_reg       <= flags_next;
            seq_reg         <= seq_next;
            last_pub_reg    <= last_pub_next;
        end
    end

    always_comb begin
        res.accepted      = accepted;
        res.published     = published;
        res.held_priority = held_prio_next;
        res.held_sticky   = held_sticky_next;
        res.change_count  = seq_next;
        res.flags         = flags_next;
        res_scene         = held_scene_next;
    end

    // Every scene change publishes, so the last published scene tracks the held one.
    a_pub_tracks_held: assert property (@(posedge aclk) disable iff (!aresetn)
        last_pub_reg == held_scene_reg)
        else $error("last published scene differs from held scene");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(seq_reg) && $stable(flags_reg) && $stable(held_scene_reg))
        else $error("state moved without an item");

    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (seq_reg == $past(seq_reg)) || (seq_reg == $past(seq_reg) + 32'd1))
        else $error("sequence counter jumped");

    a_accept_only_req: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (item.opcode != OP_REQUEST) |-> !res.accepted)
        else $error("accepted flag raised for a non-request");

    a_accept_publishes: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.accepted |=> (held_prio_reg == $past(prio_clamped)))
        else $error("accepted request did not take its priority");

endmodule
`default_nettype wire

/* hdl/priority_lease_scene_arbiter_top.sv */
`default_nettype none
// A beat accepted into the input register is processed when it fires into the state update,
// and its result beat is held in the result register until m_ready takes it.
// Throughput: one beat per cycle; the input register, the state update and the
// result register all advance together whenever the result register can move.
// Reset (aresetn low, synchronous) clears both valid flags, loads the register
// reset values and puts the default scene in place with sequence number one.
module priority_lease_scene_arbiter_top
    import plsa_pkg::*;
#(
    parameter int SCENE_ID_BITS = SCENE_ID_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_opcode,
    input  wire logic [SCENE_ID_BITS-1:0] s_scene_id,
    input  wire logic [7:0]               s_req_priority,
    input  wire logic [15:0]              s_lease_secs,
    input  wire logic                     s_req_sticky,
    input  wire logic                     s_from_user,
    input  wire logic [1:0]               s_override_sel,
    input  wire logic                     s_override_on,
    input  wire logic [31:0]              s_now_ms,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_accepted,
    output logic                          m_published,
    output logic [SCENE_ID_BITS-1:0]      m_resolved_scene,
    output logic [2:0]                    m_held_priority,
    output logic                          m_held_sticky,
    output logic [31:0]                   m_change_count,
    output logic                          m_night_flag,
    output logic                          m_thermal_flag,
    output logic                          m_offline_flag,
    output logic                          m_splash_flag
);

    cfg_t                     cfg;
    logic [SCENE_ID_BITS-1:0] default_scene;

    logic                     in_vld_reg;
    item_t                    in_item_reg;
    logic [SCENE_ID_BITS-1:0] in_scene_reg;

    logic                     out_vld_reg;
    res_t                     out_res_reg;
    logic [SCENE_ID_BITS-1:0] out_scene_reg;

    res_t                     res;
    logic [SCENE_ID_BITS-1:0] res_scene;
    logic                     fire;
    logic                     s_take;

    assign fire    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || fire;
    assign s_take  = s_valid && s_ready;

    plsa_cfg #(
        .SCENE_ID_BITS(SCENE_ID_BITS)
    ) u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cfg           (cfg),
        .default_scene (default_scene)
    );

    plsa_core #(
        .SCENE_ID_BITS(SCENE_ID_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .item          (in_item_reg),
        .scene_id      (in_scene_reg),
        .cfg           (cfg),
        .default_scene (default_scene),
        .res           (res),
        .res_scene     (res_scene)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= s_take || (in_vld_reg && !fire);
            out_vld_reg <= fire || (out_vld_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.opcode       <= op_t'(s_opcode);
            in_item_reg.req_priority <= s_req_priority;
            in_item_reg.lease_secs   <= s_lease_secs;
            in_item_reg.req_sticky   <= s_req_sticky;
            in_item_reg.from_user    <= s_from_user;
            in_item_reg.override_sel <= s_override_sel;
            in_item_reg.override_on  <= s_override_on;
            in_item_reg.now_ms       <= s_now_ms;
            in_scene_reg             <= s_scene_id;
        end
        if (fire) begin
            out_res_reg   <= res;
            out_scene_reg <= res_scene;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_accepted       = out_res_reg.accepted;
    assign m_published      = out_res_reg.published;
    assign m_resolved_scene = out_scene_reg;
    assign m_held_priority  = out_res_reg.held_priority;
    assign m_held_sticky    = out_res_reg.held_sticky;
    assign m_change_count   = out_res_reg.change_count;
    assign m_night_flag     = out_res_reg.flags[0];
    assign m_thermal_flag   = out_res_reg.flags[1];
    assign m_offline_flag   = out_res_reg.flags[2];
    assign m_splash_flag    = out_res_reg.flags[3];

endmodule
`default_nettype wire

/* test/priority_lease_scene_arbiter_top_test.sv */
module priority_lease_scene_arbiter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import plsa_pkg::*;

    localparam logic [1:0] SEL_NIGHT   = 2'd0;
    localparam logic [1:0] SEL_THERMAL = 2'd1;
    localparam logic [1:0] SEL_OFFLINE = 2'd2;
    localparam logic [1:0] SEL_SPLASH  = 2'd3;

    typedef struct packed {
        op_t         opcode;
        logic [3:0]  scene_id;
        logic [7:0]  req_priority;
        logic [15:0] lease_secs;
        logic        req_sticky;
        logic        from_user;
        logic [1:0]  override_sel;
        logic        override_on;
        logic [31:0] now_ms;
    } lease_beat_t;

    typedef struct packed {
        logic        accepted;
        logic        published;
        logic [3:0]  scene;
        logic [2:0]  prio;
        logic        sticky;
        logic [31:0] count;
        logic [3:0]  flags;   // splash, offline, thermal, night
    } lease_outcome_t;

    class lease_tracker;
        logic [2:0]  max_prio;
        logic [15:0] dflt_dur;
        logic [15:0] max_dur;
        logic [30:0] hard_ttl;
        logic [3:0]  dflt_scene;

        logic [3:0]  held_scene;
        logic [2:0]  held_prio;
        logic        held_sticky;
        logic        soft_armed;
        logic [31:0] soft_ends_at;
        logic [31:0] hard_ends_at;
        logic [3:0]  ovr;
        logic [31:0] seq;
        logic [3:0]  last_pub;

        lease_outcome_t pending_outcomes[$];
        int errors;

        function new();
            max_prio     = MAX_PRIORITY_RST;
            dflt_dur     = DEFAULT_DURATION_RST;
            max_dur      = MAX_DURATION_RST;
            hard_ttl     = HARD_TTL_RST;
            dflt_scene   = 4'(DEFAULT_SCENE_RST);
            held_scene   = dflt_scene;
            held_prio    = '0;
            held_sticky  = 1'b0;
            soft_armed   = 1'b0;
            soft_ends_at = '0;
            hard_ends_at = '0;
            ovr          = '0;
            seq          = SEQ_RST;
            last_pub     = dflt_scene;
            errors       = 0;
        endfunction

        function void set_cfg(cfg_idx_t idx, logic [30:0] v);
            case (idx)
                CFG_MAX_PRIORITY:     max_prio = v[2:0];
                CFG_DEFAULT_DURATION: dflt_dur = v[15:0];
                CFG_MAX_DURATION:     max_dur = v[15:0];
                CFG_HARD_TTL:         hard_ttl = v;
                CFG_DEFAULT_SCENE:    dflt_scene = v[3:0];
                default: ;
            endcase
        endfunction

        // Wrap-safe: the deadline counts as reached when now - deadline is not negative.
        function bit reached(logic [31:0] now, logic [31:0] deadline);
            logic [31:0] diff;
            diff = now - deadline;
            return !diff[31];
        endfunction

        function void fall_back(logic [31:0] now);
            held_scene   = dflt_scene;
            held_prio    = '0;
            held_sticky  = 1'b0;
            soft_armed   = 1'b0;
            soft_ends_at = '0;
            hard_ends_at = now + 32'(hard_ttl);
        endfunction

        function void bump();
            if (held_scene != last_pub) begin
                seq      = seq + 32'd1;
                last_pub = held_scene;
            end
        endfunction

        function void note_item(lease_beat_t b);
            logic [7:0]  p;
            logic [15:0] d;
            logic [31:0] soft_ms;
            logic [3:0]  mask;
            bit          due;
            lease_outcome_t o;
            o = '0;
            case (b.opcode)
                OP_REQUEST: begin
                    p = b.req_priority;
                    if (p > 8'(max_prio)) p = 8'(max_prio);
                    soft_ms = '0;
                    if (!b.req_sticky) begin
                        d = (b.lease_secs == 16'd0) ? dflt_dur : b.lease_secs;
                        if (d > max_dur) d = max_dur;
                        soft_ms = 32'(d) * 32'(MS_PER_S);
                    end
                    if (b.from_user || p >= 8'(held_prio)) begin
                        held_scene   = b.scene_id;
                        held_prio    = p[2:0];
                        held_sticky  = b.req_sticky;
                        soft_armed   = !b.req_sticky;
                        soft_ends_at = b.req_sticky ? 32'd0 : b.now_ms + soft_ms;
                        hard_ends_at = b.now_ms + 32'(hard_ttl);
                        o.accepted   = 1'b1;
                        o.published  = 1'b1;
                        bump();
                    end
                end
                OP_TICK: begin
                    due = (soft_armed && reached(b.now_ms, soft_ends_at)) ||
                          reached(b.now_ms, hard_ends_at);
                    if (due && !(held_scene == dflt_scene && held_prio == 3'd0 &&
                                 !held_sticky)) begin
                        fall_back(b.now_ms);
                        o.published = 1'b1;
                        bump();
                    end
                end
                OP_OVERRIDE: begin
                    mask = 4'b0001 << b.override_sel;
                    if (((ovr & mask) != 4'd0) != b.override_on) begin
                        ovr = b.override_on ? (ovr | mask) : (ovr & ~mask);
                        o.published = 1'b1;
                        bump();
                    end
                end
                OP_CLR_STICK: begin
                    if (held_sticky) begin
                        fall_back(b.now_ms);
                        o.published = 1'b1;
                        bump();
                    end
                end
                default: ;
            endcase
            o.scene  = held_scene;
            o.prio   = held_prio;
            o.sticky = held_sticky;
            o.count  = seq;
            o.flags  = ovr;
            pending_outcomes.push_back(o);
        endfunction

        function void check_outcome(lease_outcome_t got);
            lease_outcome_t want;
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result beat with nothing outstanding: scene=%0d count=%0d",
                         $time, got.scene, got.count);
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (want !== got) begin
                $display({"%0t: mismatch: expected acc=%0b pub=%0b scene=%0d prio=%0d ",
                          "sticky=%0b count=%0d flags=%b, actual acc=%0b pub=%0b scene=%0d ",
                          "prio=%0d sticky=%0b count=%0d flags=%b"},
                         $time, want.accepted, want.published, want.scene, want.prio,
                         want.sticky, want.count, want.flags, got.accepted, got.published,
                         got.scene, got.prio, got.sticky, got.count, got.flags);
                errors++;
            end
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    cfg_idx_t    cfg_index = CFG_MAX_PRIORITY;
    logic [30:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_accepted;
    logic        m_published;
    logic [3:0]  m_resolved_scene;
    logic [2:0]  m_held_priority;
    logic        m_held_sticky;
    logic [31:0] m_change_count;
    logic        m_night_flag;
    logic        m_thermal_flag;
    logic        m_offline_flag;
    logic        m_splash_flag;

    lease_beat_t  drv_beat = '0;
    lease_beat_t  last_request = '0;
    logic [31:0]  clock_ms = '0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           hold_left = 0;
    lease_tracker tracker;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    priority_lease_scene_arbiter_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (drv_beat.opcode),
        .s_scene_id       (drv_beat.scene_id),
        .s_req_priority   (drv_beat.req_priority),
        .s_lease_secs     (drv_beat.lease_secs),
        .s_req_sticky     (drv_beat.req_sticky),
        .s_from_user      (drv_beat.from_user),
        .s_override_sel   (drv_beat.override_sel),
        .s_override_on    (drv_beat.override_on),
        .s_now_ms         (drv_beat.now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_published      (m_published),
        .m_resolved_scene (m_resolved_scene),
        .m_held_priority  (m_held_priority),
        .m_held_sticky    (m_held_sticky),
        .m_change_count   (m_change_count),
        .m_night_flag     (m_night_flag),
        .m_thermal_flag   (m_thermal_flag),
        .m_offline_flag   (m_offline_flag),
        .m_splash_flag    (m_splash_flag)
    );

    // Results are checked before the input beat of the same edge is noted, so an
    // unexpected result can never be matched against that input.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_outcome({m_accepted, m_published, m_resolved_scene,
                                       m_held_priority, m_held_sticky, m_change_count,
                                       m_splash_flag, m_offline_flag, m_thermal_flag,
                                       m_night_flag});
            if (s_valid && s_ready)
                tracker.note_item(drv_beat);
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_beat(lease_beat_t b);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        drv_beat = b;
        s_valid  = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic put(op_t op, logic [3:0] scene, logic [7:0] prio, logic [15:0] dur,
                       logic sticky, logic user, logic [1:0] sel, logic on,
                       logic [31:0] now);
        send_beat({op, scene, prio, dur, sticky, user, sel, on, now});
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [30:0] v);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        tracker.set_cfg(idx, v);
        @(negedge aclk);
    endtask

    task automatic apply_settings(logic [2:0] mp, logic [15:0] dd, logic [15:0] md,
                                  logic [30:0] ttl, logic [3:0] ds);
        write_reg(CFG_MAX_PRIORITY, 31'(mp));
        write_reg(CFG_DEFAULT_DURATION, 31'(dd));
        write_reg(CFG_MAX_DURATION, 31'(md));
        write_reg(CFG_HARD_TTL, ttl);
        write_reg(CFG_DEFAULT_SCENE, 31'(ds));
        cfg_we = 1'b0;
    endtask

    // Time mostly moves forward in small steps; the longer jumps are what let
    // soft and hard deadlines expire, and the rare absolute jump wraps the clock.
    function automatic lease_beat_t random_beat();
        lease_beat_t b;
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)      clock_ms += $urandom_range(50);
        else if (pick < 80) clock_ms += $urandom_range(5000);
        else if (pick < 93) clock_ms += $urandom_range(5_000_000);
        else if (pick < 98) clock_ms += $urandom() & 32'h7FFF_FFFF;
        else                clock_ms = $urandom();
        b.scene_id     = 4'($urandom());
        b.req_priority = ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom());
        pick = $urandom_range(3);
        case (pick)
            0:       b.lease_secs = 16'd0;
            1:       b.lease_secs = 16'($urandom_range(10));
            2:       b.lease_secs = 16'($urandom_range(4000));
            default: b.lease_secs = 16'($urandom());
        endcase
        b.req_sticky   = ($urandom_range(3) == 0);
        b.from_user    = ($urandom_range(9) < 3);
        b.override_sel = 2'($urandom());
        b.override_on  = 1'($urandom());
        pick = $urandom_range(99);
        if (pick < 40)      b.opcode = OP_REQUEST;
        else if (pick < 75) b.opcode = OP_TICK;
        else if (pick < 90) b.opcode = OP_OVERRIDE;
        else                b.opcode = OP_CLR_STICK;
        // Repeating the last request exercises the refresh-only path.
        if (b.opcode == OP_REQUEST && $urandom_range(4) == 0)
            b = last_request;
        if (b.opcode == OP_REQUEST)
            last_request = b;
        b.now_ms = clock_ms;
        return b;
    endfunction

    task automatic run_random(int n);
        repeat (n) send_beat(random_beat());
    endtask

    initial begin
        tracker = new();
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        idle_pct  = 21;
        stall_pct = 21;
        put(OP_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd0);
        put(OP_REQUEST, 4'd3, 8'd255, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd1000);
        put(OP_REQUEST, 4'd4, 8'd2, 16'd5, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd2000);
        put(OP_REQUEST, 4'd4, 8'd2, 16'd0, 1'b0, 1'b1, SEL_NIGHT, 1'b0, 32'd3000);
        put(OP_REQUEST, 4'd4, 8'd2, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd4000);
        put(OP_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd30000);
        put(OP_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd34000);
        put(OP_REQUEST, 4'd15, 8'd7, 16'hFFFF, 1'b1, 1'b0, SEL_NIGHT, 1'b0, 32'd40000);
        put(OP_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd100000);
        put(OP_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd3700000);
        put(OP_CLR_STICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd3750000);
        put(OP_REQUEST, 4'd0, 8'd0, 16'd0, 1'b1, 1'b0, SEL_NIGHT, 1'b0, 32'd3800000);
        put(OP_CLR_STICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd3800100);
        put(OP_OVERRIDE, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b1, 32'd3800200);
        put(OP_OVERRIDE, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b1, 32'd3800300);
        put(OP_OVERRIDE, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_THERMAL, 1'b1, 32'd3800400);
        put(OP_OVERRIDE, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_OFFLINE, 1'b1, 32'd3800500);
        put(OP_OVERRIDE, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_SPLASH, 1'b1, 32'd3800600);
        put(OP_OVERRIDE, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd3800700);
        // A one second lease taken just before the wrap ends exactly at time zero.
        put(OP_REQUEST, 4'd5, 8'd1, 16'd1, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'hFFFF_FC18);
        put(OP_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd0);
        put(OP_REQUEST, 4'd6, 8'd3, 16'hFFFF, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd100);
        put(OP_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd3600099);
        put(OP_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd3600100);
        wait_idle();

        // The new default scene must not disturb the held one before a revert.
        apply_settings(3'd5, 16'd0, 16'd3600, 31'd3600000, 4'd9);
        put(OP_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd3600200);
        put(OP_REQUEST, 4'd2, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd5000000);
        put(OP_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 1'b0, SEL_NIGHT, 1'b0, 32'd5000000);
        wait_idle();

        clock_ms  = 32'd5000000;
        idle_pct  = 0;
        stall_pct = 0;
        apply_settings(3'd7, 16'd1, 16'd2, 31'd5000, 4'd0);
        run_random(80);
        hold_left = 300;
        run_random(80);
        wait_idle();
        run_random(100);
        wait_idle();

        idle_pct  = 76;
        stall_pct = 0;
        apply_settings(3'd0, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 4'd15);
        run_random(260);
        wait_idle();

        idle_pct  = 0;
        stall_pct = 76;
        apply_settings(3'd3, 16'd5, 16'd30, 31'd1, 4'd6);
        run_random(260);
        wait_idle();

        idle_pct  = 21;
        stall_pct = 21;
        apply_settings(MAX_PRIORITY_RST, DEFAULT_DURATION_RST, MAX_DURATION_RST,
                       HARD_TTL_RST, 4'($urandom()));
        run_random(260);
        wait_idle();
        repeat (10) @(posedge aclk);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
